@@ hw/rtl/wca_pkg.sv @@
`default_nettype none

package wca_pkg;

  localparam int COORD_BITS = 16;
  localparam int GREY_BITS  = 16;
  localparam int FRAC_BITS  = 8;

  localparam int MOMENT_W = 64;
  localparam int MASS_W   = 48;
  localparam int CENT_W   = 24;

  // Multiplier operands: a column sum of a run needs one bit more than a coordinate,
  // and a run length one bit more again once it is signed.
  localparam int OPA_W  = COORD_BITS + 2;
  localparam int OPB_W  = (GREY_BITS > COORD_BITS + 2) ? GREY_BITS : COORD_BITS + 2;
  localparam int PROD_W = OPA_W + OPB_W;

  localparam int DIV_STEPS = MOMENT_W + FRAC_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] col_start;
    logic signed [COORD_BITS-1:0] col_end;
    logic signed [COORD_BITS-1:0] row;
    logic signed [COORD_BITS-1:0] plane;
    logic signed [GREY_BITS-1:0]  grey;
    logic                         last;
  } item_t;

  typedef struct packed {
    logic signed [CENT_W-1:0] centroid_x;
    logic signed [CENT_W-1:0] centroid_y;
    logic signed [CENT_W-1:0] centroid_z;
    logic signed [MASS_W-1:0] total_mass;
    logic                     zero_mass;
    logic                     overflow;
  } result_t;

  typedef struct packed {
    logic  load_item;
    logic  mul_en;
    axis_t mul_axis;
    logic  acc_en;
    axis_t acc_axis;
    logic  mass_en;
    logic  div_load;
    logic  div_step;
    logic  cap_en;
    axis_t div_axis;
    logic  emit;
  } cmd_t;

  typedef struct packed {
    logic last;
  } stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/wca_divider.sv @@
`default_nettype none

module wca_divider (
  input  wire logic                                 clk,
  input  wire logic                                 load,
  input  wire logic                                 step,
  input  wire logic signed [wca_pkg::MOMENT_W-1:0]  dividend,
  input  wire logic signed [wca_pkg::MASS_W-1:0]    divisor,
  output logic signed [wca_pkg::CENT_W-1:0]         quot
);

  localparam int MW    = wca_pkg::MOMENT_W;
  localparam int WW    = wca_pkg::MASS_W;
  localparam int CW    = wca_pkg::CENT_W;
  localparam int DVD_W = wca_pkg::MOMENT_W + wca_pkg::FRAC_BITS;
  localparam int QW    = wca_pkg::CENT_W + wca_pkg::FRAC_BITS;
  localparam logic [QW:0] POS_LIM = (QW+1)'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic [QW:0] NEG_LIM = (QW+1)'(64'd1 << (CW - 1));
  localparam logic [QW:0] SAT_MAG = (QW+1)'(64'd1 << CW);

  logic [DVD_W-1:0] dvd;
  logic [WW-1:0]    uw;
  logic [WW-1:0]    rem;
  logic [QW-1:0]    q;
  logic             big;
  logic             neg;

  logic [MW-1:0] um_in;
  logic [WW-1:0] uw_in;
  logic [WW:0]   rem_sh;
  logic [WW:0]   uw_ext;
  logic          ge;
  logic          rnd;
  logic [QW:0]   mag;
  logic [QW:0]   lim;

  always_comb begin
    um_in  = dividend[MW-1] ? MW'(-dividend) : MW'(dividend);
    uw_in  = divisor[WW-1] ? WW'(-divisor) : WW'(divisor);
    uw_ext = {1'b0, uw};
    rem_sh = {rem, dvd[DVD_W-1]};
    ge     = (rem_sh >= uw_ext);
    rnd    = ({rem, 1'b0} >= uw_ext);
    if (big) begin
      mag = SAT_MAG;
    end else begin
      mag = (QW+1)'(q) + (QW+1)'(rnd);
    end
    if (neg) begin
      lim = (mag > NEG_LIM) ? NEG_LIM : mag;
    end else begin
      lim = (mag > POS_LIM) ? POS_LIM : mag;
    end
    quot = neg ? -lim[CW-1:0] : lim[CW-1:0];
  end

  // Restoring division, one quotient bit a cycle. Quotient bits that fall off the
  // top of q mean the integer part did not fit, and are kept as a sticky flag.
  always_ff @(posedge clk) begin
    if (load) begin
      dvd <= DVD_W'(um_in) << wca_pkg::FRAC_BITS;
      uw  <= uw_in;
      rem <= '0;
      q   <= '0;
      big <= 1'b0;
      neg <= dividend[MW-1] ^ divisor[WW-1];
    end else if (step) begin
      dvd <= dvd << 1;
      rem <= ge ? WW'(rem_sh - uw_ext) : WW'(rem_sh);
      q   <= {q[QW-2:0], ge};
      big <= big | q[QW-1];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/wca_datapath.sv @@
`default_nettype none

module wca_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_wdata,
  input  wire wca_pkg::item_t   item,
  input  wire wca_pkg::cmd_t    cmd,
  output wca_pkg::stat_t        stat,
  output wca_pkg::result_t      result
);

  localparam int CW     = wca_pkg::COORD_BITS;
  localparam int MW     = wca_pkg::MOMENT_W;
  localparam int WW     = wca_pkg::MASS_W;
  localparam int OPA_W  = wca_pkg::OPA_W;
  localparam int OPB_W  = wca_pkg::OPB_W;
  localparam int PROD_W = wca_pkg::PROD_W;
  localparam logic signed [MW-1:0] MOM_MAX  = {1'b0, {(MW-1){1'b1}}};
  localparam logic signed [MW-1:0] MOM_MIN  = {1'b1, {(MW-1){1'b0}}};
  localparam logic signed [WW-1:0] MASS_MAX = {1'b0, {(WW-1){1'b1}}};
  localparam logic signed [WW-1:0] MASS_MIN = {1'b1, {(WW-1){1'b0}}};

  logic weight_mode;
  logic signed [MW-1:0] moment_x;
  logic signed [MW-1:0] moment_y;
  logic signed [MW-1:0] moment_z;
  logic signed [WW-1:0] mass_sum;
  logic                 saturated;

  // Item registers.
  logic                      item_bin;
  logic                      last_r;
  logic signed [CW-1:0]      cs_r;
  logic signed [CW-1:0]      row_r;
  logic signed [CW-1:0]      plane_r;
  logic signed [CW:0]        ends_r;
  logic signed [OPB_W-1:0]   wgt_r;
  logic signed [PROD_W-1:0]  prod;

  logic signed [wca_pkg::CENT_W-1:0] cent_x;
  logic signed [wca_pkg::CENT_W-1:0] cent_y;
  logic signed [wca_pkg::CENT_W-1:0] cent_z;

  logic signed [CW:0]       ends_in;
  logic signed [CW+1:0]     cnt_in;
  logic                     run_ok;
  logic signed [OPB_W-1:0]  wgt_in;
  logic signed [OPA_W-1:0]  opa;
  logic signed [PROD_W-1:0] addend;
  logic signed [MW-1:0]     acc_sel;
  logic signed [MW:0]       acc_sum;
  logic                     acc_ovf;
  logic signed [MW-1:0]     acc_res;
  logic signed [WW:0]       mass_in;
  logic                     mass_ovf;
  logic signed [WW-1:0]     mass_res;
  logic signed [MW-1:0]     div_sel;
  logic signed [wca_pkg::CENT_W-1:0] div_quot;
  logic                     zm;

  always_comb begin
    ends_in = (CW+1)'(item.col_start) + (CW+1)'(item.col_end);
    cnt_in  = (CW+2)'(item.col_end) - (CW+2)'(item.col_start) + (CW+2)'(1);
    run_ok  = (item.col_end >= item.col_start);
    if (!weight_mode) begin
      wgt_in = OPB_W'(item.grey);
    end else if (run_ok) begin
      wgt_in = OPB_W'(cnt_in);
    end else begin
      wgt_in = '0;
    end
  end

  always_comb begin
    case (cmd.mul_axis)
      wca_pkg::AXIS_X: opa = item_bin ? OPA_W'(ends_r) : OPA_W'(cs_r);
      wca_pkg::AXIS_Y: opa = OPA_W'(row_r);
      wca_pkg::AXIS_Z: opa = OPA_W'(plane_r);
      default:         opa = '0;
    endcase
  end

  // (first + last) * count of a run is always even, so the halving is exact.
  always_comb begin
    if (cmd.acc_axis == wca_pkg::AXIS_X && item_bin) begin
      addend = prod >>> 1;
    end else begin
      addend = prod;
    end
    case (cmd.acc_axis)
      wca_pkg::AXIS_X: acc_sel = moment_x;
      wca_pkg::AXIS_Y: acc_sel = moment_y;
      wca_pkg::AXIS_Z: acc_sel = moment_z;
      default:         acc_sel = '0;
    endcase
    acc_sum = (MW+1)'(acc_sel) + (MW+1)'(addend);
    acc_ovf = cmd.acc_en && (acc_sum[MW] != acc_sum[MW-1]);
    if (acc_sum[MW] != acc_sum[MW-1]) begin
      acc_res = acc_sum[MW] ? MOM_MIN : MOM_MAX;
    end else begin
      acc_res = acc_sum[MW-1:0];
    end
    mass_in  = (WW+1)'(mass_sum) + (WW+1)'(wgt_r);
    mass_ovf = cmd.mass_en && (mass_in[WW] != mass_in[WW-1]);
    if (mass_in[WW] != mass_in[WW-1]) begin
      mass_res = mass_in[WW] ? MASS_MIN : MASS_MAX;
    end else begin
      mass_res = mass_in[WW-1:0];
    end
  end

  always_comb begin
    case (cmd.div_axis)
      wca_pkg::AXIS_X: div_sel = moment_x;
      wca_pkg::AXIS_Y: div_sel = moment_y;
      wca_pkg::AXIS_Z: div_sel = moment_z;
      default:         div_sel = '0;
    endcase
    zm = (mass_sum == '0);
  end

  wca_divider u_div (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (div_sel),
    .divisor  (mass_sum),
    .quot     (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_mode <= 1'b0;
      moment_x    <= '0;
      moment_y    <= '0;
      moment_z    <= '0;
      mass_sum    <= '0;
      saturated   <= 1'b0;
    end else begin
      if (cfg_we) begin
        weight_mode <= cfg_wdata;
      end
      if (cmd.emit) begin
        moment_x  <= '0;
        moment_y  <= '0;
        moment_z  <= '0;
        mass_sum  <= '0;
        saturated <= 1'b0;
      end else begin
        if (cmd.acc_en) begin
          case (cmd.acc_axis)
            wca_pkg::AXIS_X: moment_x <= acc_res;
            wca_pkg::AXIS_Y: moment_y <= acc_res;
            wca_pkg::AXIS_Z: moment_z <= acc_res;
            default:         moment_x <= moment_x;
          endcase
        end
        if (cmd.mass_en) begin
          mass_sum <= mass_res;
        end
        saturated <= saturated | acc_ovf | mass_ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_bin <= weight_mode;
      last_r   <= item.last;
      cs_r     <= item.col_start;
      row_r    <= item.row;
      plane_r  <= item.plane;
      ends_r   <= ends_in;
      wgt_r    <= wgt_in;
    end
    if (cmd.mul_en) begin
      prod <= opa * wgt_r;
    end
    if (cmd.cap_en) begin
      case (cmd.div_axis)
        wca_pkg::AXIS_X: cent_x <= zm ? '0 : div_quot;
        wca_pkg::AXIS_Y: cent_y <= zm ? '0 : div_quot;
        wca_pkg::AXIS_Z: cent_z <= zm ? '0 : div_quot;
        default:         cent_x <= cent_x;
      endcase
    end
    if (cmd.emit) begin
      result.centroid_x <= cent_x;
      result.centroid_y <= cent_y;
      result.centroid_z <= cent_z;
      result.total_mass <= mass_sum;
      result.zero_mass  <= zm;
      result.overflow   <= saturated;
    end
  end

  assign stat.last = last_r;

endmodule

`default_nettype wire

@@ hw/rtl/wca_ctrl.sv @@
`default_nettype none

module wca_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire wca_pkg::stat_t stat,
  output logic                busy,
  output logic                done,
  output wca_pkg::cmd_t       cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_ACC_Z,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DIV_CAP,
    ST_EMIT
  } state_t;

  localparam int SW = wca_pkg::STEP_W;

  state_t                 state;
  wca_pkg::axis_t         axis;
  logic [SW-1:0]          step_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      axis     <= wca_pkg::AXIS_X;
      step_cnt <= '0;
      done     <= 1'b0;
    end else begin
      done <= (state == ST_EMIT);
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_MUL_X;
          end
        end
        ST_MUL_X: state <= ST_MUL_Y;
        ST_MUL_Y: state <= ST_MUL_Z;
        ST_MUL_Z: state <= ST_ACC_Z;
        ST_ACC_Z: begin
          axis  <= wca_pkg::AXIS_X;
          state <= stat.last ? ST_DIV_LOAD : ST_IDLE;
        end
        ST_DIV_LOAD: begin
          step_cnt <= '0;
          state    <= ST_DIV_RUN;
        end
        ST_DIV_RUN: begin
          step_cnt <= step_cnt + SW'(1);
          if (step_cnt == SW'(wca_pkg::DIV_STEPS - 1)) begin
            state <= ST_DIV_CAP;
          end
        end
        ST_DIV_CAP: begin
          case (axis)
            wca_pkg::AXIS_X: begin
              axis  <= wca_pkg::AXIS_Y;
              state <= ST_DIV_LOAD;
            end
            wca_pkg::AXIS_Y: begin
              axis  <= wca_pkg::AXIS_Z;
              state <= ST_DIV_LOAD;
            end
            default: state <= ST_EMIT;
          endcase
        end
        ST_EMIT: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state != ST_IDLE);

  // The multiplier works one axis ahead of the accumulator.
  always_comb begin
    cmd          = '0;
    cmd.mul_axis = wca_pkg::AXIS_X;
    cmd.acc_axis = wca_pkg::AXIS_X;
    cmd.div_axis = axis;
    case (state)
      ST_IDLE:  cmd.load_item = start;
      ST_MUL_X: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_axis = wca_pkg::AXIS_X;
      end
      ST_MUL_Y: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_axis = wca_pkg::AXIS_Y;
        cmd.acc_en   = 1'b1;
        cmd.acc_axis = wca_pkg::AXIS_X;
      end
      ST_MUL_Z: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_axis = wca_pkg::AXIS_Z;
        cmd.acc_en   = 1'b1;
        cmd.acc_axis = wca_pkg::AXIS_Y;
      end
      ST_ACC_Z: begin
        cmd.acc_en   = 1'b1;
        cmd.acc_axis = wca_pkg::AXIS_Z;
        cmd.mass_en  = 1'b1;
      end
      ST_DIV_LOAD: cmd.div_load = 1'b1;
      ST_DIV_RUN:  cmd.div_step = 1'b1;
      ST_DIV_CAP:  cmd.cap_en   = 1'b1;
      ST_EMIT:     cmd.emit     = 1'b1;
      default:     cmd.load_item = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/weighted_centroid_accumulator.sv @@
// Each beat is taken when start is high and busy is low; busy then stays high while
// one shared multiplier works over x, y and z, and no new item is taken until it falls.
// A beat with last set also runs three 72-step divisions, one bit a cycle,
// and done rises with the result after the third division is captured and emitted.
// The result is valid only in the cycle that done is high; the receiver cannot stall it.
// Synchronous reset clears the sums, the saturation flag and weight_mode.
`default_nettype none

module weighted_centroid_accumulator (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire wca_pkg::item_t   item,
  input  wire logic             cfg_we,
  input  wire logic             cfg_wdata,
  output logic                  done,
  output wca_pkg::result_t      result
);

  wca_pkg::cmd_t  cmd;
  wca_pkg::stat_t stat;

  wca_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  wca_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

endmodule

`default_nettype wire

@@ hw/rtl/wca_checker.sv @@
`default_nettype none

module wca_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done,
  input wire wca_pkg::result_t result
);

  // A result only appears once the block has gone back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not make the block busy");

  a_strobe_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_zero_cent: assert property (@(posedge clk) disable iff (rst)
    (done && result.zero_mass) |->
      (result.centroid_x == '0 && result.centroid_y == '0 && result.centroid_z == '0))
    else $error("zero mass with nonzero centroid");

  a_zero_total: assert property (@(posedge clk) disable iff (rst)
    (done && result.zero_mass) |-> (result.total_mass == '0))
    else $error("zero mass flag with nonzero total mass");

endmodule

bind weighted_centroid_accumulator wca_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
